// ===== hdl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the url percent decoder
// Item and result payloads, the per-item bundle passed between front and back,
// and the character codes the decoder recognizes.
// ----------------------------------------------------------------------------
package upd_pkg;

	// special characters
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// slots of one bundle: broken-escape percent, held digit, main byte
	localparam int unsigned NUM_SLOTS = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} out_item_t;

	// every result caused by one input item
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] data;
		logic [NUM_SLOTS-1:0]      mask;
		logic                      last;
	} bundle_t;

endpackage

// ===== hdl/url_percent_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_unit: url and form-urlencoded percent decoder
// The first result of a byte goes through the bundle queue and then the output
// register. Throughput: one input byte per cycle; results leave one per cycle
// while the output is free or popped, so a broken escape that flushes 3 bytes
// holds the queue head until all have left, and intake stalls only once the four-entry bundle queue is full.
// Reset: asynchronous, clears the escape state and empties the queue and the output.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  upd_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output upd_pkg::out_item_t result
);
	import upd_pkg::*;

	logic    accept;
	logic    b_push;
	bundle_t b_wdata;
	logic    q_full;
	logic    q_pop;
	logic    q_valid;
	bundle_t q_rdata;

	assign full   = q_full;
	assign accept = push && !q_full;

	// intake and classification
	upd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.bundle_push (b_push),
		.bundle      (b_wdata)
	);

	// bundle queue
	upd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (b_push),
		.wr_data  (b_wdata),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rdata)
	);

	// result delivery
	upd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(b_push && q_full))
		else $error("bundle queue written while full");

	// queue never popped while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("bundle queue popped while empty");

	// a bare end marker carries a zero byte and the last flag
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.out_valid) |-> (result.out_last && result.out_byte == 8'h00))
		else $error("malformed end marker");

	// every queued bundle holds a byte or ends a string
	a_bundle_content: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (q_rdata.mask != '0 || q_rdata.last))
		else $error("empty bundle in queue");

endmodule

// ===== hdl/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front: item intake and escape classification
// Runs the percent-escape state machine on each accepted byte and pushes one
// bundle with every result byte that it causes, if it causes one or ends a string.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  upd_pkg::in_item_t item,
	output logic              bundle_push,
	output upd_pkg::bundle_t  bundle
);
	import upd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PCT   = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;

	logic [1:0] stage_q;
	logic [7:0] held_q;
	logic [1:0] nxt_stage;
	logic [7:0] nxt_held;
	logic [7:0] b;
	logic       last;
	logic       b_hex;
	logic [7:0] idle_val;
	logic       idle_open;
	logic [7:0] decoded;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		hex_value = c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

	// byte decode
	assign b         = item.in_byte;
	assign last      = item.in_last;
	assign b_hex     = is_hex(b);
	assign idle_val  = (b == CH_PLUS) ? CH_SPACE : b;
	assign idle_open = (b == CH_PERCENT) && !last;
	assign decoded   = {hex_value(held_q), hex_value(b)};

	// escape state machine and bundle build
	always_comb begin
		nxt_stage   = stage_q;
		nxt_held    = held_q;
		bundle.data = {8'h00, held_q, CH_PERCENT};
		bundle.mask = '0;
		bundle.last = last;
		unique case (stage_q)
			ST_PCT: begin
				if (b_hex && !last) begin
					nxt_stage = ST_DIGIT;
					nxt_held  = b;
				end else begin
					bundle.mask[0] = 1'b1;
					nxt_stage      = idle_open ? ST_PCT : ST_IDLE;
					bundle.data[2] = idle_val;
					bundle.mask[2] = !idle_open && (idle_val != 8'h00);
				end
			end
			ST_DIGIT: begin
				if (b_hex) begin
					nxt_stage      = ST_IDLE;
					bundle.data[2] = decoded;
					bundle.mask[2] = (decoded != 8'h00);
				end else begin
					bundle.mask[0] = 1'b1;
					bundle.mask[1] = 1'b1;
					nxt_stage      = idle_open ? ST_PCT : ST_IDLE;
					bundle.data[2] = idle_val;
					bundle.mask[2] = !idle_open && (idle_val != 8'h00);
				end
			end
			default: begin
				nxt_stage      = idle_open ? ST_PCT : ST_IDLE;
				bundle.data[2] = idle_val;
				bundle.mask[2] = !idle_open && (idle_val != 8'h00);
			end
		endcase
		if (last) begin
			nxt_stage = ST_IDLE;
			nxt_held  = 8'h00;
		end
	end

	assign bundle_push = accept && ((bundle.mask != '0) || last);

	// escape state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			held_q  <= 8'h00;
		end else if (accept) begin
			stage_q <= nxt_stage;
			held_q  <= nxt_held;
		end
	end

endmodule

// ===== hdl/upd_fifo.sv =====
// ----------------------------------------------------------------------------
// upd_fifo: bundle queue between front and back
// Four-entry register queue so intake and result delivery stall independently.
// ----------------------------------------------------------------------------
module upd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  upd_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic             rd_valid,
	output upd_pkg::bundle_t rd_data
);
	import upd_pkg::*;

	bundle_t    mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	assign full     = (count_q == 3'd4);
	assign rd_valid = (count_q != 3'd0);
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'b00, wr_en} - {2'b00, rd_en};
		end
	end

endmodule

// ===== hdl/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back: result serializer
// Moves the head bundle's present slots into an output register, one result
// per cycle while free or popped; an empty bundle yields a bare end marker.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  upd_pkg::bundle_t    q_data,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output upd_pkg::out_item_t  result
);
	import upd_pkg::*;

	logic [NUM_SLOTS-1:0] sent_q;
	logic [NUM_SLOTS-1:0] rem;
	logic [NUM_SLOTS-1:0] pick;
	logic                 single;
	logic                 final_one;
	logic                 emit;
	logic                 occ_q;
	out_item_t            res_q;
	out_item_t            nxt_res;

	// slots still to send from the head bundle
	assign rem = q_data.mask & ~sent_q;

	// oldest remaining slot
	always_comb begin
		unique case (rem) inside
			3'b000:  pick = 3'b000;
			3'b001, 3'b011, 3'b101, 3'b111: pick = 3'b001;
			3'b010, 3'b110: pick = 3'b010;
			default: pick = 3'b100;
		endcase
	end

	assign single    = (rem == 3'b001) || (rem == 3'b010) || (rem == 3'b100);
	assign final_one = single || (rem == 3'b000);
	assign emit      = q_valid && (!occ_q || pop);
	assign q_pop     = emit && final_one;

	// next result
	always_comb begin
		nxt_res.out_byte  = 8'h00;
		nxt_res.out_valid = (rem != 3'b000);
		nxt_res.out_last  = q_data.last && final_one;
		if (pick[0]) begin
			nxt_res.out_byte = q_data.data[0];
		end else if (pick[1]) begin
			nxt_res.out_byte = q_data.data[1];
		end else if (pick[2]) begin
			nxt_res.out_byte = q_data.data[2];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= nxt_res;
		end
	end

	// slot tracking and output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
			occ_q  <= 1'b0;
		end else begin
			if (emit) begin
				sent_q <= final_one ? '0 : (sent_q | pick);
				occ_q  <= 1'b1;
			end else if (pop) begin
				occ_q <= 1'b0;
			end
		end
	end

	assign empty  = !occ_q;
	assign result = res_q;

endmodule

// ===== sim/url_percent_decoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_unit_test: self-checking bench for the percent decoder
// Feeds encoded strings (hand-picked corner cases, then random strings built
// mostly from valid escapes with some broken ones and noise) through the
// push/full side. A model of the decode predicts every result
// beat, and each popped beat is checked field by field in order.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit_test;
	import upd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 40000;
	localparam int unsigned TAIL_CYCLES  = 10;
	localparam int unsigned RANDOM_ITEMS = 260;
	localparam int unsigned IDLE_PCT     = 33;

	// escape progress of the decode model
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PCT   = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;

	localparam string HEX_CHARS = "0123456789abcdefABCDEF";

	logic      clk    = 1'b0;
	logic      arst_n = 1'b1;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  item   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	in_item_t    pending_bytes[$];
	out_item_t   decoded_q[$];
	out_item_t   burst_q[$];
	out_item_t   want;
	logic [1:0]  esc_stage  = ST_IDLE;
	logic [7:0]  held_digit = 8'h00;
	int unsigned errors     = 0;
	int unsigned cycles     = 0;
	int unsigned n_accepted = 0;

	url_percent_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial forever #2 clk = ~clk;

	// decode model
	function automatic bit is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] nibble(logic [7:0] c);
		return c[6] ? c[3:0] + 4'd9 : c[3:0];
	endfunction

	// zero bytes never leave the decoder
	function void emit_byte(logic [7:0] b);
		if (b != 8'h00)
			burst_q.push_back(out_item_t'{out_byte: b, out_valid: 1'b1, out_last: 1'b0});
	endfunction

	function void from_idle(logic [7:0] b, logic last);
		if (b == CH_PERCENT && !last) begin
			esc_stage = ST_PCT;
			return;
		end
		esc_stage = ST_IDLE;
		emit_byte(b == CH_PLUS ? CH_SPACE : b);
	endfunction

	function void decode_byte(in_item_t it);
		burst_q.delete();
		case (esc_stage)
			ST_PCT: begin
				if (is_hex(it.in_byte) && !it.in_last) begin
					held_digit = it.in_byte;
					esc_stage  = ST_DIGIT;
				end else begin
					esc_stage = ST_IDLE;
					emit_byte(CH_PERCENT);
					from_idle(it.in_byte, it.in_last);
				end
			end
			ST_DIGIT: begin
				esc_stage = ST_IDLE;
				if (is_hex(it.in_byte)) begin
					emit_byte({nibble(held_digit), nibble(it.in_byte)});
				end else begin
					emit_byte(CH_PERCENT);
					emit_byte(held_digit);
					from_idle(it.in_byte, it.in_last);
				end
			end
			default: from_idle(it.in_byte, it.in_last);
		endcase
		// end of string: bare marker when nothing else came out
		if (it.in_last) begin
			esc_stage  = ST_IDLE;
			held_digit = 8'h00;
			if (burst_q.size() == 0)
				burst_q.push_back(out_item_t'{out_byte: 8'h00, out_valid: 1'b0,
					out_last: 1'b0});
			burst_q[burst_q.size()-1].out_last = 1'b1;
		end
		foreach (burst_q[i])
			decoded_q.push_back(burst_q[i]);
	endfunction

	// stimulus helpers
	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			pending_bytes.push_back(in_item_t'{in_byte: s[i], in_last: (i == s.len() - 1)});
	endtask

	function automatic logic [7:0] random_hex();
		return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
	endfunction

	task automatic add_random_string();
		logic [7:0] text[$];
		int unsigned len;
		int unsigned pick;
		len = $urandom_range(1, 10);
		while (text.size() < len) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				text.push_back(CH_PERCENT);
				text.push_back(random_hex());
				text.push_back(random_hex());
			end else if (pick < 50) begin
				text.push_back(CH_PLUS);
			end else if (pick < 58) begin
				text.push_back(CH_PERCENT);
				text.push_back(8'($urandom_range(255)));
			end else if (pick < 64) begin
				text.push_back(CH_PERCENT);
				text.push_back(random_hex());
				text.push_back(8'($urandom_range(255)));
			end else if (pick < 70) begin
				text.push_back(CH_PERCENT);
			end else if (pick < 74) begin
				text.push_back(8'h00);
			end else begin
				text.push_back(8'($urandom_range(255)));
			end
		end
		foreach (text[i])
			pending_bytes.push_back(in_item_t'{in_byte: text[i],
				in_last: (i == text.size() - 1)});
	endtask

	// no idling while the middle of the run goes through
	function bit take_break();
		if (n_accepted >= 120 && n_accepted < 180)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	task automatic report(string what, int got, int exp_val);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, exp_val);
		errors++;
	endtask

	// driver: both handshake sides change on the falling edge
	always @(negedge clk) begin
		if (arst_n && pending_bytes.size() != 0 && !take_break()) begin
			push <= 1'b1;
			item <= pending_bytes[0];
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && !take_break();
	end

	// monitor: accepted input beats feed the model, result beats are checked
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			if (arst_n && push && !full) begin
				decode_byte(pending_bytes.pop_front());
				n_accepted++;
			end
			if (arst_n && pop && !empty) begin
				if (decoded_q.size() == 0) begin
					report("unexpected beat", result, 0);
				end else begin
					want = decoded_q.pop_front();
					if (result.out_byte != want.out_byte)
						report("out_byte", result.out_byte, want.out_byte);
					if (result.out_valid != want.out_valid)
						report("out_valid", result.out_valid, want.out_valid);
					if (result.out_last != want.out_last)
						report("out_last", result.out_last, want.out_last);
				end
			end
		end
	end

	initial begin
		// falling reset edge at time zero
		arst_n <= 1'b0;
		// plain escapes, both digit cases, plus as space
		add_text("%41");
		add_text("%6a+");
		// decoded zero on the last byte leaves only a bare end marker
		add_text("%00");
		pending_bytes.push_back(in_item_t'{in_byte: 8'h00, in_last: 1'b1});
		// high bytes pass as they are
		pending_bytes.push_back(in_item_t'{in_byte: 8'hFF, in_last: 1'b0});
		pending_bytes.push_back(in_item_t'{in_byte: 8'h80, in_last: 1'b1});
		// broken escapes, with and without a held digit
		add_text("%G");
		add_text("%4G");
		// held digit broken by a percent on the last byte: three beats
		add_text("%4%");
		// lone percent at string end
		add_text("%");
		// percent breaking an escape opens a new one, cut by the end
		add_text("%%4");
		add_text("Z%4");

		while (pending_bytes.size() < RANDOM_ITEMS)
			add_random_string();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_bytes.size() == 0 && decoded_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
